FILE: rtl/ibi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibi_pkg: shared types and constants of the interpolation bucket index
// Command codes, controller states, table geometry and the header layout.
// ----------------------------------------------------------------------------
package ibi_pkg;

    localparam int MAX_BUCKET_BITS = 12;
    localparam int MIN_BUCKET_BITS = 2;
    localparam int TABLE_DEPTH     = 1 << MAX_BUCKET_BITS;

    localparam int KEY_W   = 64;
    localparam int EST_W   = 40;
    localparam int REC_W   = 40;
    localparam int OFF_W   = 41;
    localparam int WORD_W  = 64;
    localparam int BB_W    = 4;
    localparam int IDX_W   = MAX_BUCKET_BITS;
    localparam int CFG_W   = 40;
    localparam int KTOP_W  = KEY_W - EST_W;       // key bits used for prediction
    localparam int SPLIT_W = EST_W / 2;           // estimate split for partial products
    localparam int PP_W    = KTOP_W + SPLIT_W;
    localparam int PRED_SH = 24;

    localparam logic [15:0] HEADER_ID = 16'h4161;

    localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_ESTIMATE    = 1'b0,
        REG_BUCKET_BITS = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        S_INIT,     // sweep after reset
        S_CLEAR,    // sweep for a clear command
        S_IDLE,     // ready for a transfer
        S_PRED,     // prediction sum, table read in flight
        S_EXEC      // compare, write back, load result
    } t_state;

    // Clamp the configured bucket bits into the supported range.
    function automatic logic [BB_W-1:0] eff_bits(input logic [BB_W-1:0] raw);
        logic [BB_W-1:0] b;
        b = raw;
        if (b < BB_W'(MIN_BUCKET_BITS)) begin
            b = BB_W'(MIN_BUCKET_BITS);
        end
        if (b > BB_W'(MAX_BUCKET_BITS)) begin
            b = BB_W'(MAX_BUCKET_BITS);
        end
        return b;
    endfunction

endpackage

FILE: rtl/ibi_predict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibi_predict: predicted record number
// Computes ((key >> 40) * estimate) >> 24 from two registered partial
// products, then a registered sum.
// ----------------------------------------------------------------------------
module ibi_predict (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [ibi_pkg::KTOP_W-1:0]   i_key_top,
    input  logic [ibi_pkg::EST_W-1:0]    i_estimate,
    output logic [ibi_pkg::REC_W-1:0]    o_pred
);

    logic [ibi_pkg::PP_W-1:0]  r_pp_lo;
    logic [ibi_pkg::PP_W-1:0]  r_pp_hi;
    logic [ibi_pkg::REC_W-1:0] r_pred;
    logic [ibi_pkg::KEY_W-1:0] w_sum;

    // Capture both partial products with the accepted item.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pp_lo <= ibi_pkg::PP_W'(i_key_top)
                     * ibi_pkg::PP_W'(i_estimate[ibi_pkg::SPLIT_W-1:0]);
            r_pp_hi <= ibi_pkg::PP_W'(i_key_top)
                     * ibi_pkg::PP_W'(i_estimate[ibi_pkg::EST_W-1:ibi_pkg::SPLIT_W]);
        end
    end

    assign w_sum = ibi_pkg::KEY_W'(r_pp_lo)
                 + (ibi_pkg::KEY_W'(r_pp_hi) << ibi_pkg::SPLIT_W);

    always_ff @(posedge i_clk) begin
        r_pred <= w_sum[ibi_pkg::PRED_SH +: ibi_pkg::REC_W];
    end

    assign o_pred = r_pred;

endmodule

FILE: rtl/interpolation_bucket_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interpolation_bucket_index: correction table for interpolation search
// Keeps one signed offset per key bucket in an on-chip memory; updates lower
// offsets, lookups return the scan start slot, reads return table words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   clear, update, lookup or read of a table word. Every command yields exactly
//   one transfer on the output channel (o_out_valid / i_out_stall).
//   Configuration (estimate, bucket bits) goes through i_cfg_we / i_cfg_index /
//   i_cfg_data; the user must change it only while no command is outstanding,
//   as the block itself does not enforce this. For update, lookup and read
//   the command passes through S_IDLE, S_PRED and S_EXEC; o_out_valid rises
//   when the result is registered at the end of S_EXEC. The input is taken
//   again in the cycle after the result is registered, so the block takes no
//   new command before the last one is through. These three steps are set by
//   the table memory (registered read, write back in the last step) and the
//   split multiply of the prediction. Clear walks the whole table, one entry
//   per cycle, then passes through S_EXEC, where the result is loaded.
//   After reset the same sweep zeroes the table; o_in_stall is high meanwhile.
//   Configuration writes are taken at any time. A stalled receiver holds the
//   result register; one further command is taken and worked up to its last
//   step, where it waits until the output register frees.
// ----------------------------------------------------------------------------
module interpolation_bucket_index (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_cmd,
    input  logic [ibi_pkg::KEY_W-1:0]           i_key_high,
    input  logic [ibi_pkg::REC_W-1:0]           i_record_number,
    input  logic [ibi_pkg::IDX_W-1:0]           i_word_index,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ibi_pkg::OFF_W-1:0]    o_seek_record,
    output logic signed [ibi_pkg::WORD_W-1:0]   o_table_word,
    // configuration
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [ibi_pkg::CFG_W-1:0]           i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ibi_pkg::EST_W-1:0] r_estimate;
    logic [ibi_pkg::BB_W-1:0]  r_bucket_bits;
    logic [ibi_pkg::BB_W-1:0]  w_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_estimate    <= '0;
            r_bucket_bits <= ibi_pkg::BB_W'(ibi_pkg::MIN_BUCKET_BITS);
        end else if (i_cfg_we) begin
            case (ibi_pkg::t_reg'(i_cfg_index))
                ibi_pkg::REG_ESTIMATE:    r_estimate    <= i_cfg_data[ibi_pkg::EST_W-1:0];
                ibi_pkg::REG_BUCKET_BITS: r_bucket_bits <= i_cfg_data[ibi_pkg::BB_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_bb = ibi_pkg::eff_bits(r_bucket_bits);

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    ibi_pkg::t_state r_state;
    ibi_pkg::t_state n_state;
    logic [ibi_pkg::IDX_W-1:0] r_sweep;
    logic [ibi_pkg::IDX_W-1:0] n_sweep;
    logic w_in_accept;
    logic w_out_free;
    logic w_out_load;

    assign o_in_stall  = (r_state != ibi_pkg::S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !o_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Captured command
    // ------------------------------------------------------------------
    ibi_pkg::t_cmd             r_cmd;
    logic [ibi_pkg::REC_W-1:0] r_rec;
    logic [ibi_pkg::IDX_W-1:0] r_widx;
    logic [ibi_pkg::IDX_W-1:0] r_addr;
    logic [ibi_pkg::IDX_W-1:0] n_addr;
    logic [ibi_pkg::IDX_W-1:0] w_bucket;

    // Bucket is the top bb bits of the key.
    assign w_bucket = i_key_high[ibi_pkg::KEY_W-1 -: ibi_pkg::IDX_W]
                      >> (ibi_pkg::BB_W'(ibi_pkg::MAX_BUCKET_BITS) - w_bb);
    assign n_addr   = (i_cmd == ibi_pkg::CMD_READ) ? i_word_index : w_bucket;

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cmd  <= ibi_pkg::t_cmd'(i_cmd);
            r_rec  <= i_record_number;
            r_widx <= i_word_index;
            r_addr <= n_addr;
        end
    end

    // ------------------------------------------------------------------
    // Prediction unit: partial products at accept, sum registered in the cycle after
    // ------------------------------------------------------------------
    logic [ibi_pkg::REC_W-1:0] w_pred;

    ibi_predict u_predict (
        .i_clk      (i_clk),
        .i_load     (w_in_accept),
        .i_key_top  (i_key_high[ibi_pkg::KEY_W-1 -: ibi_pkg::KTOP_W]),
        .i_estimate (r_estimate),
        .o_pred     (w_pred)
    );

    // ------------------------------------------------------------------
    // Offset memory: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [ibi_pkg::OFF_W-1:0] r_mem [ibi_pkg::TABLE_DEPTH];
    logic [ibi_pkg::OFF_W-1:0] r_rd_data;
    logic [ibi_pkg::IDX_W-1:0] w_rd_addr;
    logic                      w_mem_we;
    logic [ibi_pkg::IDX_W-1:0] w_mem_waddr;
    logic [ibi_pkg::OFF_W-1:0] w_mem_wdata;

    // Read the incoming address while idle, then hold the captured one.
    assign w_rd_addr = (r_state == ibi_pkg::S_IDLE) ? n_addr : r_addr;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // ------------------------------------------------------------------
    // Execute step arithmetic
    // ------------------------------------------------------------------
    logic signed [ibi_pkg::OFF_W-1:0]  w_off;
    logic signed [ibi_pkg::OFF_W-1:0]  w_diff;
    logic signed [ibi_pkg::OFF_W-1:0]  w_seek_pred;
    logic                              w_bucket_nz;
    logic                              w_lower;
    logic                              w_in_table;
    logic [ibi_pkg::WORD_W-1:0]        w_header;
    logic signed [ibi_pkg::OFF_W-1:0]  n_seek;
    logic signed [ibi_pkg::WORD_W-1:0] n_word;

    assign w_off       = signed'(r_rd_data);
    assign w_diff      = signed'({1'b0, r_rec}) - signed'({1'b0, w_pred});
    assign w_seek_pred = signed'({1'b0, w_pred}) + w_off;
    assign w_bucket_nz = (r_addr != '0);
    assign w_lower     = (w_diff < w_off);
    assign w_in_table  = ((r_widx >> w_bb) == '0);
    assign w_header    = {ibi_pkg::HEADER_ID, 4'b0000, w_bb, r_estimate};

    always_comb begin
        n_seek = '0;
        n_word = '0;
        case (r_cmd)
            ibi_pkg::CMD_LOOKUP: begin
                if (w_bucket_nz) begin
                    n_seek = w_seek_pred;
                    n_word = ibi_pkg::WORD_W'(w_off);
                end else begin
                    // bucket zero: table size in record slots
                    n_seek = ibi_pkg::OFF_W'(1)
                             << (w_bb - ibi_pkg::BB_W'(ibi_pkg::MIN_BUCKET_BITS));
                end
            end
            ibi_pkg::CMD_READ: begin
                if (r_widx == '0) begin
                    n_word = signed'(w_header);
                end else if (w_in_table) begin
                    n_word = ibi_pkg::WORD_W'(w_off);
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ibi_pkg::S_INIT: begin
                if (r_sweep == ibi_pkg::SWEEP_LAST) n_state = ibi_pkg::S_IDLE;
            end
            ibi_pkg::S_CLEAR: begin
                if (r_sweep == ibi_pkg::SWEEP_LAST) n_state = ibi_pkg::S_EXEC;
            end
            ibi_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_state = (i_cmd == ibi_pkg::CMD_CLEAR) ? ibi_pkg::S_CLEAR
                                                             : ibi_pkg::S_PRED;
                end
            end
            ibi_pkg::S_PRED: n_state = ibi_pkg::S_EXEC;
            ibi_pkg::S_EXEC: begin
                if (w_out_free) n_state = ibi_pkg::S_IDLE;
            end
            default: n_state = ibi_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs of the controller: sweep writes, write back, result load
    // ------------------------------------------------------------------
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_waddr = r_addr;
        w_mem_wdata = w_diff;
        w_out_load  = 1'b0;
        n_sweep     = r_sweep;
        case (r_state)
            ibi_pkg::S_INIT, ibi_pkg::S_CLEAR: begin
                // zero one entry per cycle, wrap back to zero at the end
                w_mem_we    = 1'b1;
                w_mem_waddr = r_sweep;
                w_mem_wdata = '0;
                n_sweep     = r_sweep + 1'b1;
            end
            ibi_pkg::S_EXEC: begin
                w_out_load = w_out_free;
                w_mem_we   = w_out_free && (r_cmd == ibi_pkg::CMD_UPDATE)
                             && w_bucket_nz && w_lower;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibi_pkg::S_INIT;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                              r_out_valid;
    logic signed [ibi_pkg::OFF_W-1:0]  r_seek;
    logic signed [ibi_pkg::WORD_W-1:0] r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_seek <= n_seek;
            r_word <= n_word;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_seek_record = r_seek;
    assign o_table_word  = r_word;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> !(r_out_valid && i_out_stall))
        else $error("result register loaded while a stalled result waits");

    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == ibi_pkg::S_PRED || r_state == ibi_pkg::S_CLEAR))
        else $error("accepted command did not start work");

    a_write_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mem_we && r_state == ibi_pkg::S_EXEC) |-> w_mem_wdata[ibi_pkg::OFF_W-1])
        else $error("offset write back is not negative");

    a_sweep_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ibi_pkg::S_IDLE) |-> (r_sweep == '0))
        else $error("sweep counter not at rest while idle");

    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |-> (r_state == ibi_pkg::S_INIT || r_state == ibi_pkg::S_CLEAR
                      || r_state == ibi_pkg::S_EXEC))
        else $error("table written outside sweep or write back");

endmodule
